/* rtl/uhb_pkg.sv */
// Package for the undo/redo history buffer.
// Command and status codes, controller state type and the control bundle.
// No dependencies.
`default_nettype none

package uhb_pkg;

    // Command codes on the cmd port
    localparam logic [2:0] CMD_PUSH     = 3'd0;
    localparam logic [2:0] CMD_PUSH_CUR = 3'd1;
    localparam logic [2:0] CMD_RETARD   = 3'd2;
    localparam logic [2:0] CMD_ADVANCE  = 3'd3;
    localparam logic [2:0] CMD_TRUNCATE = 3'd4;
    localparam logic [2:0] CMD_MARK     = 3'd5;
    localparam logic [2:0] CMD_QUERY    = 3'd6;

    // Status codes on the status port
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BOUNDARY = 2'd1;
    localparam logic [1:0] STAT_MARKED   = 2'd2;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } uhb_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // command transfer taken this cycle
        logic exec;   // execute the latched command
    } uhb_ctl_t;

endpackage

`default_nettype wire

/* rtl/uhb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module uhb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/uhb_ctrl.sv */
// Controller for the undo/redo history buffer: idle / execute sequencer.
// Depends on uhb_pkg.
`default_nettype none

module uhb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    output uhb_pkg::uhb_ctl_t    ctl
);

    import uhb_pkg::*;

    uhb_state_t state_reg;
    uhb_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                ctl.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/uhb_datapath.sv */
// Datapath for the undo/redo history buffer: length, cursor, pending mark,
// cached cursor entry, entry memory and result registers.
// Depends on uhb_pkg and uhb_ram.
`default_nettype none

module uhb_datapath #(
    parameter int DEPTH     = 256,
    parameter int MOVE_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire uhb_pkg::uhb_ctl_t          ctl,
    input  wire logic [2:0]                 cmd,
    input  wire logic [MOVE_BITS-1:0]       move,
    output logic                            done,
    output logic [1:0]                      status,
    output logic                            entry_valid,
    output logic [MOVE_BITS-1:0]            entry_move,
    output logic                            entry_mark,
    output logic [$clog2(DEPTH+1)-1:0]      position,
    output logic [$clog2(DEPTH+1)-1:0]      total
);

    import uhb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = MOVE_BITS + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // Latched command
    logic [2:0]           cmd_reg;
    logic [MOVE_BITS-1:0] move_reg;

    // Buffer state
    logic [CW-1:0] count_reg,   count_next;
    logic [CW-1:0] cursor_reg,  cursor_next;
    logic          pending_reg, pending_next;

    // Copy of the entry under the cursor (meaningful while cursor < count)
    logic [MOVE_BITS-1:0] cur_move_reg, cur_move_next;
    logic                 cur_mark_reg, cur_mark_next;

    // Result registers
    logic                 done_reg;
    logic [1:0]           status_reg,   status_next;
    logic                 valid_reg,    valid_next;
    logic [MOVE_BITS-1:0] emove_reg,    emove_next;
    logic                 emark_reg,    emark_next;

    // Memory port signals
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [CW-1:0] raddr_full;
    logic [EW-1:0] rdata;

    logic cur_valid;
    logic push_path;
    logic full;

    // Read address: retard and advance prefetch the neighbor entry
    always_comb
    begin
        raddr_full = cursor_reg;
        case (cmd)
            CMD_RETARD:  raddr_full = cursor_reg - ONE;
            CMD_ADVANCE: raddr_full = cursor_reg + ONE;
            default:     raddr_full = cursor_reg;
        endcase
    end

    uhb_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.load),
        .raddr (raddr_full[AW-1:0]),
        .rdata (rdata)
    );

    // Command latch
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            move_reg <= move;
        end
    end

    assign cur_valid = cursor_reg < count_reg;
    assign full      = count_reg == FULL_COUNT;
    assign push_path = (cmd_reg == CMD_PUSH) || ((cmd_reg == CMD_PUSH_CUR) && !cur_valid);

    // Command execution
    always_comb
    begin
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        pending_next  = pending_reg;
        cur_move_next = cur_move_reg;
        cur_mark_next = cur_mark_reg;
        status_next   = STAT_OK;
        we            = 1'b0;
        waddr         = cursor_reg[AW-1:0];
        wdata         = {cur_mark_reg, move_reg};

        if (push_path)
        begin
            // append at the tail
            if (full)
            begin
                status_next = STAT_BOUNDARY;
            end
            else
            begin
                we           = 1'b1;
                waddr        = count_reg[AW-1:0];
                wdata        = {pending_reg, move_reg};
                count_next   = count_reg + ONE;
                pending_next = 1'b0;
                if (!cur_valid)
                begin
                    cur_move_next = move_reg;
                    cur_mark_next = pending_reg;
                end
            end
        end
        else
        begin
            case (cmd_reg)
                CMD_PUSH_CUR:
                begin
                    // overwrite under the cursor, keep its mark
                    we            = 1'b1;
                    wdata         = {cur_mark_reg, move_reg};
                    count_next    = cursor_reg + ONE;
                    pending_next  = 1'b0;
                    cur_move_next = move_reg;
                end
                CMD_RETARD:
                begin
                    if (cursor_reg == '0)
                    begin
                        status_next = STAT_BOUNDARY;
                    end
                    else
                    begin
                        cursor_next   = cursor_reg - ONE;
                        cur_move_next = rdata[MOVE_BITS-1:0];
                        cur_mark_next = rdata[MOVE_BITS];
                        status_next   = rdata[MOVE_BITS] ? STAT_MARKED : STAT_OK;
                    end
                end
                CMD_ADVANCE:
                begin
                    if (!cur_valid)
                    begin
                        status_next = STAT_BOUNDARY;
                    end
                    else
                    begin
                        cursor_next   = cursor_reg + ONE;
                        cur_move_next = rdata[MOVE_BITS-1:0];
                        cur_mark_next = rdata[MOVE_BITS];
                        status_next   = (cursor_next >= count_reg) ? STAT_BOUNDARY
                                                                   : STAT_OK;
                    end
                end
                CMD_TRUNCATE:
                begin
                    if (cursor_reg == '0)
                    begin
                        count_next   = '0;
                        pending_next = 1'b0;
                    end
                    else
                    begin
                        pending_next = cur_valid ? cur_mark_reg : 1'b0;
                        count_next   = cursor_reg;
                    end
                end
                CMD_MARK:
                begin
                    if (cur_valid)
                    begin
                        we            = 1'b1;
                        wdata         = {1'b1, cur_move_reg};
                        cur_mark_next = 1'b1;
                    end
                    else
                    begin
                        pending_next = 1'b1;
                    end
                end
                default:
                begin
                    // query and unused codes change nothing
                end
            endcase
        end

        // result view of the cursor entry
        valid_next = cursor_next < count_next;
        emove_next = valid_next ? cur_move_next : '0;
        emark_next = valid_next & cur_mark_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cursor_reg  <= '0;
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.exec;
            if (ctl.exec)
            begin
                count_reg   <= count_next;
                cursor_reg  <= cursor_next;
                pending_reg <= pending_next;
            end
        end
    end

    // Cached entry and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            cur_move_reg <= cur_move_next;
            cur_mark_reg <= cur_mark_next;
            status_reg   <= status_next;
            valid_reg    <= valid_next;
            emove_reg    <= emove_next;
            emark_reg    <= emark_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_valid = valid_reg;
    assign entry_move  = emove_reg;
    assign entry_mark  = emark_reg;
    assign position    = cursor_reg;
    assign total       = count_reg;

endmodule

`default_nettype wire

/* rtl/undo_history_buffer_top.sv */
// Top level of the undo/redo history buffer.
// Depends on uhb_pkg, uhb_ctrl, uhb_datapath (and uhb_ram below it).
//
//   channel   handshake            payload
//   command   start / busy         cmd, move
//   result    done (1-cycle pulse) status, entry_valid, entry_move, entry_mark,
//                                  position, total
//
// Every command has a transfer cycle, which prefetches the neighbor entry for
// retard and advance from the single-port-read entry memory, and an execute
// cycle, which updates the state and does any memory write. done pulses in the
// cycle after execute, which is also when the next command can be taken.
// Reset clears length, cursor and pending mark; the memory is not cleared.
// The receiver cannot stall; each result is present for exactly one cycle.
`default_nettype none

module undo_history_buffer_top #(
    parameter int DEPTH     = 256,
    parameter int MOVE_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [2:0]                 cmd,
    input  wire logic [MOVE_BITS-1:0]       move,
    output logic                            done,
    output logic [1:0]                      status,
    output logic                            entry_valid,
    output logic [MOVE_BITS-1:0]            entry_move,
    output logic                            entry_mark,
    output logic [$clog2(DEPTH+1)-1:0]      position,
    output logic [$clog2(DEPTH+1)-1:0]      total
);

    import uhb_pkg::*;

    uhb_ctl_t ctl;

    uhb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    uhb_datapath #(
        .DEPTH     (DEPTH),
        .MOVE_BITS (MOVE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (cmd),
        .move        (move),
        .done        (done),
        .status      (status),
        .entry_valid (entry_valid),
        .entry_move  (entry_move),
        .entry_mark  (entry_mark),
        .position    (position),
        .total       (total)
    );

endmodule

`default_nettype wire

/* tb/uhb_checker.sv */
// Scoreboard for the undo/redo history buffer: tracks the history state from
// the command transfers and checks every result pulse against it.
// Depends on uhb_pkg.
`default_nettype none

module uhb_checker #(
    parameter int DEPTH     = 256,
    parameter int MOVE_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [2:0]                 cmd,
    input  wire logic [MOVE_BITS-1:0]       move,
    input  wire logic                       done,
    input  wire logic [1:0]                 status,
    input  wire logic                       entry_valid,
    input  wire logic [MOVE_BITS-1:0]       entry_move,
    input  wire logic                       entry_mark,
    input  wire logic [$clog2(DEPTH+1)-1:0] position,
    input  wire logic [$clog2(DEPTH+1)-1:0] total,
    output int                              fail_count,
    output int                              outstanding
);

    import uhb_pkg::*;

    localparam int PW = $clog2(DEPTH+1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] LEN_ONE  = PW'(1);
    localparam logic [PW-1:0] LEN_FULL = PW'(DEPTH);

    typedef struct packed {
        logic [1:0]           status;
        logic                 valid;
        logic [MOVE_BITS-1:0] mv;
        logic                 mk;
        logic [PW-1:0]        pos;
        logic [PW-1:0]        len;
    } history_view_t;

    // Shadow copy of the history
    logic [MOVE_BITS-1:0] hist_move [DEPTH];
    logic                 hist_mark [DEPTH];
    logic [PW-1:0]        hist_len;
    logic [PW-1:0]        hist_cur;
    logic                 mark_pend;

    history_view_t        expected_views [$];
    int                   results_seen;

    task automatic report_mismatch(input string msg);
        $display("history check: result %0d: %s", results_seen, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Append at the tail; refused when the history is full
    task automatic append_entry(input logic [MOVE_BITS-1:0] mv, output logic [1:0] st);
        if (hist_len == LEN_FULL)
        begin
            st = STAT_BOUNDARY;
        end
        else
        begin
            hist_move[hist_len[AW-1:0]] = mv;
            hist_mark[hist_len[AW-1:0]] = mark_pend;
            hist_len                    = hist_len + LEN_ONE;
            mark_pend                   = 1'b0;
            st                          = STAT_OK;
        end
    endtask

    // Apply one command to the shadow state and queue the view it produces
    task automatic predict_history(input logic [2:0] c, input logic [MOVE_BITS-1:0] mv);
        logic [1:0]    st;
        logic          vld;
        history_view_t view;
        st = STAT_OK;
        case (c)
            CMD_PUSH:
            begin
                append_entry(mv, st);
            end
            CMD_PUSH_CUR:
            begin
                if (hist_cur < hist_len)
                begin
                    hist_move[hist_cur[AW-1:0]] = mv;
                    hist_len                    = hist_cur + LEN_ONE;
                    mark_pend                   = 1'b0;
                end
                else
                begin
                    append_entry(mv, st);
                end
            end
            CMD_RETARD:
            begin
                if (hist_cur == '0)
                begin
                    st = STAT_BOUNDARY;
                end
                else
                begin
                    hist_cur = hist_cur - LEN_ONE;
                    st = hist_mark[hist_cur[AW-1:0]] ? STAT_MARKED : STAT_OK;
                end
            end
            CMD_ADVANCE:
            begin
                if (hist_cur >= hist_len)
                begin
                    st = STAT_BOUNDARY;
                end
                else
                begin
                    hist_cur = hist_cur + LEN_ONE;
                    if (hist_cur >= hist_len)
                        st = STAT_BOUNDARY;
                end
            end
            CMD_TRUNCATE:
            begin
                if (hist_cur == '0)
                begin
                    hist_len  = '0;
                    mark_pend = 1'b0;
                end
                else
                begin
                    // a cut at the cursor carries its mark over to the next push
                    mark_pend = (hist_cur < hist_len) ? hist_mark[hist_cur[AW-1:0]] : 1'b0;
                    hist_len  = hist_cur;
                end
            end
            CMD_MARK:
            begin
                if (hist_cur < hist_len)
                    hist_mark[hist_cur[AW-1:0]] = 1'b1;
                else
                    mark_pend = 1'b1;
            end
            default:
            begin
                // query and the unused code change nothing
            end
        endcase

        vld         = hist_cur < hist_len;
        view.status = st;
        view.valid  = vld;
        view.mv     = vld ? hist_move[hist_cur[AW-1:0]] : '0;
        view.mk     = vld ? hist_mark[hist_cur[AW-1:0]] : 1'b0;
        view.pos    = hist_cur;
        view.len    = hist_len;
        expected_views.push_back(view);
    endtask

    // Sample mid-cycle: inputs and outputs are stable between rising edges.
    // A result pulse belongs to an earlier transfer, so it is checked first.
    always @(negedge clk or negedge rst_n)
    begin
        history_view_t want;
        if (!rst_n)
        begin
            hist_len  = '0;
            hist_cur  = '0;
            mark_pend = 1'b0;
            expected_views.delete();
            results_seen = 0;
            outstanding  = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_views.size() == 0)
                begin
                    report_mismatch("result with no command outstanding");
                end
                else
                begin
                    want = expected_views.pop_front();
                    check_field("status", 64'(status), 64'(want.status));
                    check_field("entry_valid", 64'(entry_valid), 64'(want.valid));
                    check_field("entry_move", 64'(entry_move), 64'(want.mv));
                    check_field("entry_mark", 64'(entry_mark), 64'(want.mk));
                    check_field("position", 64'(position), 64'(want.pos));
                    check_field("total", 64'(total), 64'(want.len));
                end
                results_seen++;
            end
            if (start === 1'b1 && busy === 1'b0)
                predict_history(cmd, move);
            outstanding = expected_views.size();
        end
    end

endmodule

`default_nettype wire

/* tb/undo_history_buffer_top_tb.sv */
// Testbench top for the undo/redo history buffer: drives command transfers
// (directed, then random in phases with varying idle gaps) and gives the verdict.
// Depends on uhb_pkg, uhb_checker and the undo_history_buffer_top RTL.
`default_nettype none

module undo_history_buffer_top_tb;
    import uhb_pkg::*;

    localparam int DEPTH       = 256;
    localparam int MOVE_BITS   = 16;
    localparam int PW          = $clog2(DEPTH+1);
    localparam int LIMIT       = 300000;
    localparam int PHASE_ITEMS = 215;
    localparam int FILL_ITEMS  = 270;

    // code outside the defined set, must behave as a query
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic [2:0]           cmd;
    logic [MOVE_BITS-1:0] move;

    wire logic                 busy;
    wire logic                 done;
    wire logic [1:0]           status;
    wire logic                 entry_valid;
    wire logic [MOVE_BITS-1:0] entry_move;
    wire logic                 entry_mark;
    wire logic [PW-1:0]        position;
    wire logic [PW-1:0]        total;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int idle_pct;
    int transfers = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    undo_history_buffer_top #(
        .DEPTH     (DEPTH),
        .MOVE_BITS (MOVE_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .move        (move),
        .done        (done),
        .status      (status),
        .entry_valid (entry_valid),
        .entry_move  (entry_move),
        .entry_mark  (entry_mark),
        .position    (position),
        .total       (total)
    );

    uhb_checker #(
        .DEPTH     (DEPTH),
        .MOVE_BITS (MOVE_BITS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .move        (move),
        .done        (done),
        .status      (status),
        .entry_valid (entry_valid),
        .entry_move  (entry_move),
        .entry_mark  (entry_mark),
        .position    (position),
        .total       (total),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [MOVE_BITS-1:0] random_payload();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return MOVE_BITS'($urandom_range(0, (1 << MOVE_BITS) - 1));
        endcase
    endfunction

    function automatic logic [2:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 24)      return CMD_PUSH;
        else if (r < 34) return CMD_PUSH_CUR;
        else if (r < 54) return CMD_RETARD;
        else if (r < 70) return CMD_ADVANCE;
        else if (r < 77) return CMD_TRUNCATE;
        else if (r < 88) return CMD_MARK;
        else if (r < 94) return CMD_QUERY;
        else             return CMD_UNUSED;
    endfunction

    // Random gap before the next command; start drops only if there is one
    task automatic idle_gap();
        int n;
        n = 0;
        while ($urandom_range(99) < idle_pct)
            n++;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // One command transfer; returns at the rising edge that takes it
    task automatic issue_cmd(input logic [2:0] c, input logic [MOVE_BITS-1:0] mv);
        bit taken;
        idle_gap();
        start <= 1'b1;
        cmd   <= c;
        move  <= mv;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        transfers++;
    endtask

    // Random mix: single commands plus runs of pushes and cursor moves,
    // which is what gets the cursor deep into the history and back to zero
    task automatic run_random(input int quota);
        int n;
        int k;
        int mode;
        n = 0;
        while (n < quota)
        begin
            mode = $urandom_range(99);
            if (mode < 60)
            begin
                issue_cmd(pick_cmd(), random_payload());
                n++;
            end
            else if (mode < 75)
            begin
                k = $urandom_range(1, 20);
                repeat (k) issue_cmd(($urandom_range(3) == 0) ? CMD_PUSH_CUR : CMD_PUSH,
                                     random_payload());
                n += k;
            end
            else if (mode < 87)
            begin
                k = $urandom_range(1, 30);
                repeat (k) issue_cmd(CMD_RETARD, random_payload());
                n += k;
            end
            else
            begin
                k = $urandom_range(1, 30);
                repeat (k) issue_cmd(CMD_ADVANCE, random_payload());
                n += k;
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = CMD_QUERY;
        move     = '0;
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-history boundaries, pending mark, overwrite, cuts
        issue_cmd(CMD_QUERY, '0);
        issue_cmd(CMD_RETARD, '0);           // cursor at zero
        issue_cmd(CMD_ADVANCE, '0);          // already past the tail
        issue_cmd(CMD_TRUNCATE, '0);         // clear on empty
        issue_cmd(CMD_MARK, '0);             // past tail: pending mark
        issue_cmd(CMD_PUSH, 16'hFFFF);       // takes the pending mark
        issue_cmd(CMD_PUSH, 16'h0000);
        issue_cmd(CMD_PUSH, 16'h5A5A);
        issue_cmd(CMD_ADVANCE, '0);
        issue_cmd(CMD_ADVANCE, '0);
        issue_cmd(CMD_ADVANCE, '0);          // steps past the tail
        issue_cmd(CMD_ADVANCE, '0);
        issue_cmd(CMD_PUSH_CUR, 16'hA5A5);   // past tail acts as push
        issue_cmd(CMD_MARK, '0);
        issue_cmd(CMD_RETARD, '0);
        issue_cmd(CMD_PUSH_CUR, 16'h1234);   // overwrite and cut
        issue_cmd(CMD_RETARD, '0);
        issue_cmd(CMD_RETARD, '0);           // lands on a marked entry
        issue_cmd(CMD_RETARD, '0);
        issue_cmd(CMD_ADVANCE, '0);
        issue_cmd(CMD_MARK, '0);
        issue_cmd(CMD_TRUNCATE, '0);         // mark carried to pending
        issue_cmd(CMD_PUSH, 16'h7FFF);
        issue_cmd(CMD_UNUSED, 16'h8000);
        issue_cmd(CMD_RETARD, '0);
        issue_cmd(CMD_RETARD, '0);
        issue_cmd(CMD_TRUNCATE, '0);         // cut at zero clears all
        issue_cmd(CMD_PUSH, 16'h0001);
        issue_cmd(CMD_ADVANCE, '0);
        issue_cmd(CMD_TRUNCATE, '0);         // past tail, cursor nonzero

        // Random phases: no gaps, heavy gaps, no gaps, light gaps
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 63;
                3:       idle_pct = 17;
                default: idle_pct = 0;
            endcase
            if (phase == 3)
                repeat (FILL_ITEMS) issue_cmd(CMD_PUSH, random_payload());  // fill up
            run_random(PHASE_ITEMS);
        end
        start <= 1'b0;

        // Drain
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/uhb_pkg.sv
rtl/uhb_ram.sv
rtl/uhb_ctrl.sv
rtl/uhb_datapath.sv
rtl/undo_history_buffer_top.sv
tb/uhb_checker.sv
tb/undo_history_buffer_top_tb.sv
